// ===== hdl/ote_pkg.sv =====
package ote_pkg;

  localparam int unsigned MaxPixels = 16384;
  localparam int unsigned NumBins   = 256;
  localparam int unsigned BinW      = $clog2(MaxPixels + 1);
  localparam int unsigned IdxW      = 8;
  localparam int unsigned SumW      = BinW + IdxW;
  localparam int unsigned PW        = SumW + BinW;
  localparam int unsigned HalfW     = PW / 2;
  localparam int unsigned SqW       = 2 * PW;
  localparam int unsigned DenW      = 2 * BinW;
  localparam int unsigned CrossW    = SqW + DenW;
  localparam int unsigned QDepth    = 2;

  typedef struct packed {
    logic [IdxW-1:0] pixel_value;
    logic            last_pixel;
  } pix_t;

  typedef struct packed {
    logic [IdxW-1:0] threshold;
    logic            overflowed;
  } res_t;

  typedef enum logic [3:0] {
    S_COUNT,
    S_TOTAL_RD,
    S_TOTAL_ACC,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_SCAN_MUL,
    S_SCAN_DIFF,
    S_SCAN_SQ,
    S_SCAN_CMP,
    S_SCAN_CROSS,
    S_EMIT,
    S_CLEAR
  } bk_state_e;

endpackage

// ===== hdl/ote_if.sv =====
interface ote_pix_if;
  import ote_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ote_res_if;
  import ote_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ote_ram.sv =====
module ote_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/ote_front.sv =====
module ote_front import ote_pkg::*; (
  ote_pix_if.sink       in_i,
  output logic          push_o,
  output pix_t          push_data_o,
  input  logic          full_i
);
  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i;
  assign push_data_o = in_i.data;
endmodule

// ===== hdl/ote_queue.sv =====
module ote_queue import ote_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output pix_t pop_data_o
);
  localparam int unsigned PtrW = $clog2(QDepth);

  pix_t            slot_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o     = cnt_q == (PtrW+1)'(QDepth);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end
endmodule

// ===== hdl/ote_back.sv =====
module ote_back import ote_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  pix_t      pop_data_i,
  output logic      pop_o,
  ote_res_if.source out_o
);
  bk_state_e state_q, state_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [BinW-1:0] wdata, rdata;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [1:0]       k_q, k_d;
  logic [BinW-1:0]  cnt_q;
  logic             ovf_q;
  logic [SumW-1:0]  total_q;
  logic [BinW-1:0]  wbg_q;
  logic [SumW-1:0]  sbg_q;
  logic [PW-1:0]    p_q, q_q;
  logic [DenW-1:0]  den_q, best_den_q;
  logic [PW-1:0]    a_q;
  logic [SqW-1:0]   sq_q, best_sq_q;
  logic [CrossW-1:0] lhs_q, rhs_q;
  logic [IdxW-1:0]  best_t_q;
  logic             out_valid_q;
  res_t             out_q;
  logic             last_q;
  logic [IdxW-1:0]  pix_q;
  logic             pend_q;

  logic [BinW-1:0] wbg_nx;
  logic [SumW-1:0] sbg_nx;
  logic [BinW-1:0] wfg_nx;

  logic [HalfW-1:0]      a_half;
  logic [PW+HalfW-1:0]   sq_pp;
  logic [1:0]            csel;
  logic [HalfW+DenW-1:0] lhs_pp, rhs_pp;

  ote_ram #(.Width(BinW), .Depth(NumBins)) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign wbg_nx = wbg_q + rdata;
  assign sbg_nx = sbg_q + SumW'(rdata) * SumW'(idx_q);
  assign wfg_nx = cnt_q - wbg_nx;

  // square in two halves, cross products in four chunks from the top down
  assign a_half = k_q[0] ? a_q[PW-1:HalfW] : a_q[HalfW-1:0];
  assign sq_pp  = (PW+HalfW)'(a_q) * (PW+HalfW)'(a_half);
  assign csel   = ~k_q;
  assign lhs_pp = (HalfW+DenW)'(sq_q[csel*HalfW +: HalfW]) * (HalfW+DenW)'(best_den_q);
  assign rhs_pp = (HalfW+DenW)'(best_sq_q[csel*HalfW +: HalfW]) * (HalfW+DenW)'(den_q);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // count path: pop, read bin, then write increment next cycle
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_COUNT: begin
        if (pend_q && last_q) begin
          state_d = S_TOTAL_RD;
        end
      end
      S_TOTAL_RD:  state_d = S_TOTAL_ACC;
      S_TOTAL_ACC: state_d = (idx_q == '1) ? S_SCAN_RD : S_TOTAL_RD;
      S_SCAN_RD:   state_d = S_SCAN_ACC;
      S_SCAN_ACC: begin
        if (wbg_nx == '0) begin
          state_d = (idx_q == '1) ? S_EMIT : S_SCAN_RD;
        end else if (wfg_nx == '0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SCAN_MUL;
        end
      end
      S_SCAN_MUL:   state_d = S_SCAN_DIFF;
      S_SCAN_DIFF:  state_d = S_SCAN_SQ;
      S_SCAN_SQ:    state_d = k_q[0] ? S_SCAN_CROSS : S_SCAN_SQ;
      S_SCAN_CROSS: state_d = (k_q == '1) ? S_SCAN_CMP : S_SCAN_CROSS;
      S_SCAN_CMP:   state_d = (idx_q == '1) ? S_EMIT : S_SCAN_RD;
      S_EMIT:       state_d = out_valid_q ? S_EMIT : S_CLEAR;
      S_CLEAR:      state_d = (idx_q == '1) ? S_COUNT : S_CLEAR;
      default:      state_d = S_COUNT;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    we    = 1'b0;
    waddr = idx_q;
    wdata = '0;
    raddr = idx_q;
    idx_d = idx_q;
    k_d   = '0;
    case (state_q)
      S_COUNT: begin
        pop_o = !empty_i && !(pend_q && last_q)
                && !(pend_q && pop_data_i.pixel_value == pix_q);
        raddr = pop_data_i.pixel_value;
        waddr = pix_q;
        we    = pend_q && (cnt_q < BinW'(MaxPixels));
        wdata = rdata + 1'b1;
        idx_d = '0;
      end
      S_TOTAL_ACC, S_SCAN_CMP, S_CLEAR: idx_d = idx_q + 1'b1;
      S_SCAN_ACC: begin
        if (wbg_nx == '0) begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN_SQ:    k_d = k_q[0] ? '0 : k_q + 1'b1;
      S_SCAN_CROSS: k_d = k_q + 1'b1;
      S_EMIT: begin
        idx_d = '0;
      end
      default: ;
    endcase
    if (state_q == S_CLEAR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_COUNT: begin
          if (pend_q) begin
            if (cnt_q < BinW'(MaxPixels)) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
          pend_q <= pop_o;
          last_q <= pop_o && pop_data_i.last_pixel;
        end
        S_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
          end
          pend_q <= 1'b0;
          last_q <= 1'b0;
        end
        S_CLEAR: begin
          if (idx_q == '1) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_COUNT: begin
        pix_q      <= pop_data_i.pixel_value;
        total_q    <= '0;
        wbg_q      <= '0;
        sbg_q      <= '0;
        best_sq_q  <= '0;
        best_den_q <= DenW'(1);
        best_t_q   <= '0;
      end
      S_TOTAL_ACC: total_q <= total_q + SumW'(rdata) * SumW'(idx_q);
      S_SCAN_ACC: begin
        wbg_q <= wbg_nx;
        sbg_q <= sbg_nx;
      end
      S_SCAN_MUL: begin
        p_q   <= PW'(sbg_q) * PW'(cnt_q);
        q_q   <= PW'(total_q) * PW'(wbg_q);
        den_q <= DenW'(wbg_q) * DenW'(cnt_q - wbg_q);
      end
      S_SCAN_DIFF: a_q <= (p_q >= q_q) ? p_q - q_q : q_q - p_q;
      S_SCAN_SQ: begin
        if (!k_q[0]) begin
          sq_q <= SqW'(sq_pp);
        end else begin
          sq_q <= sq_q + (SqW'(sq_pp) << HalfW);
        end
      end
      S_SCAN_CROSS: begin
        if (k_q == '0) begin
          lhs_q <= CrossW'(lhs_pp);
          rhs_q <= CrossW'(rhs_pp);
        end else begin
          lhs_q <= (lhs_q << HalfW) + CrossW'(lhs_pp);
          rhs_q <= (rhs_q << HalfW) + CrossW'(rhs_pp);
        end
      end
      S_SCAN_CMP: begin
        if (lhs_q > rhs_q) begin
          best_sq_q  <= sq_q;
          best_den_q <= den_q;
          best_t_q   <= idx_q;
        end
      end
      S_EMIT: begin
        if (!out_valid_q) begin
          out_q.threshold  <= best_t_q;
          out_q.overflowed <= ovf_q;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/otsu_threshold_engine_top.sv =====
// Otsu threshold engine: pixels stream in at one item per cycle while a frame
// is counted (a pixel equal to the one just before it waits for that bin's
// write, since the bin memory has one read and one write port). The last pixel
// of a frame starts a pass that sums the histogram, then a scan that scores
// each threshold with nonzero background and foreground weight, ending after
// the last one or once the foreground weight is zero. The result is then held
// in an output register and a clearing pass runs before the next frame; the
// same clearing pass runs after reset. Up to two items wait in the queue while
// the summing pass, the scan and the clearing pass run; then the input stalls.
module otsu_threshold_engine_top import ote_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ote_pix_if.sink   in_i,
  ote_res_if.source out_o
);
  logic push, full, pop, empty;
  pix_t push_data, pop_data;

  ote_front u_front (
    .in_i,
    .push_o (push), .push_data_o (push_data), .full_i (full)
  );

  ote_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push), .push_data_i (push_data), .full_o (full),
    .pop_i (pop), .empty_o (empty), .pop_data_o (pop_data)
  );

  ote_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty), .pop_data_i (pop_data), .pop_o (pop), .out_o
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !pop) else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("result dropped");
endmodule
